FILE: src/gse_pkg.sv
// Package for the Gaussian scanner eye: sequencer states, shared unit
// operations, register indexes and the fixed widths of the datapath.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package gse_pkg;

    // Shared arithmetic unit widths.
    localparam int ALU_W  = 58;   // multiply product and divide dividend/quotient
    localparam int DIVR_W = 50;   // divisor and partial remainder
    localparam int CNT_W  = 6;    // step counter of the shared unit
    localparam int NUM_W  = 11;   // d*d once it is below the cut-off
    localparam int T_W    = 47;   // series term
    localparam int ACC_W  = 50;   // series sum
    localparam int WT_W   = 17;   // Q16 weight, 65536 means 1.0
    localparam int DK_W   = 14;   // den*k

    localparam int MUL_STEPS = NUM_W;
    localparam int DIV_STEPS = ALU_W;

    localparam logic [6:0]       MAX_TERMS  = 7'd80;
    localparam logic [10:0]      CUTOFF_MUL = 11'd12;
    localparam logic [T_W-1:0]   T_INIT     = T_W'(64'h1_0000_0000);
    localparam logic [ALU_W-1:0] RECIP_NUM  = ALU_W'(64'h1_0000_0000_0000);
    localparam logic [WT_W-1:0]  WEIGHT_ONE = WT_W'(65536);

    // Output field widths.
    localparam int IDX_W = 6;
    localparam int COL_W = 8;
    localparam int EYE_W = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAME,
        ST_PIXEL,
        ST_MUL,
        ST_MUL_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_RECIP,
        ST_RECIP_WAIT,
        ST_EMIT
    } gse_state_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } gse_op_t;

    typedef enum logic [1:0] {
        REG_EYE_RED,
        REG_EYE_GREEN,
        REG_EYE_BLUE,
        REG_EYE_SIZE
    } gse_reg_t;

    typedef struct packed {
        logic    start;
        gse_op_t op;
    } gse_alu_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } gse_alu_stat_t;

endpackage

`default_nettype wire

FILE: src/gse_alu.sv
// Shared iterative arithmetic unit: shift-add multiply and restoring divide,
// one bit per cycle, both through a single adder.
// Depends on gse_pkg.
`default_nettype none

module gse_alu (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gse_pkg::gse_alu_req_t         req,
    input  logic [gse_pkg::ALU_W-1:0]     opa,
    input  logic [gse_pkg::DIVR_W-1:0]    opb,
    output gse_pkg::gse_alu_stat_t        stat,
    output logic [gse_pkg::ALU_W-1:0]     result
);

    localparam int AW = gse_pkg::ALU_W;
    localparam int BW = gse_pkg::DIVR_W;

    gse_pkg::gse_op_t          op_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [gse_pkg::CNT_W-1:0] cnt_reg;
    logic [AW-1:0]             a_reg;
    logic [BW-1:0]             b_reg;
    logic [AW-1:0]             r_reg;

    logic [AW-1:0] add_x;
    logic [AW-1:0] add_y;
    logic          add_c;
    logic [AW:0]   sum;

    // Multiply: r += a when the low multiplier bit is set.
    // Divide: the shifted remainder minus the divisor; the carry says it fits.
    always_comb begin
        if (op_reg == gse_pkg::OP_MUL) begin
            add_x = r_reg;
            add_y = b_reg[0] ? a_reg : '0;
            add_c = 1'b0;
        end else begin
            add_x = AW'({r_reg[BW-1:0], a_reg[AW-1]});
            add_y = ~AW'(b_reg);
            add_c = 1'b1;
        end
        sum = {1'b0, add_x} + {1'b0, add_y} + (AW+1)'(add_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= gse_pkg::OP_MUL;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == gse_pkg::OP_MUL)
                          ? gse_pkg::CNT_W'(gse_pkg::MUL_STEPS - 1)
                          : gse_pkg::CNT_W'(gse_pkg::DIV_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= opa;
            b_reg <= opb;
            r_reg <= '0;
        end else if (busy_reg) begin
            if (op_reg == gse_pkg::OP_MUL) begin
                if (b_reg[0]) begin
                    r_reg <= sum[AW-1:0];
                end
                a_reg <= {a_reg[AW-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[BW-1:1]};
            end else begin
                if (sum[AW]) begin
                    r_reg <= AW'(sum[BW-1:0]);
                end else begin
                    r_reg <= add_x;
                end
                a_reg <= {a_reg[AW-2:0], sum[AW]};
            end
        end
    end

    assign result    = (op_reg == gse_pkg::OP_MUL) ? r_reg : a_reg;
    assign stat.done = done_reg;
    assign stat.zero = (result == '0);

endmodule

`default_nettype wire

FILE: src/gaussian_scanner_eye.sv
// Top level of the Gaussian scanner eye: frame sequencer, configuration
// registers and output register around the shared arithmetic unit.
// Depends on gse_pkg and gse_alu.
`default_nettype none

// Every accepted beat with frame_tick set renders one frame: LEDS output
// beats, LED 0 first, the last one marked by m_tlast and, when the scan
// counter has wrapped to zero, by m_tuser. The block takes no new beat until
// the whole frame has been handed to the output register. Each LED's weight
// comes from an exponential series summed by one shared multiply/divide unit
// that retires one bit per cycle: a series term is a multiply (a start state,
// one step per multiplier bit and a hand-over), then a divide (a start state,
// one step per dividend bit and a hand-over), and the final reciprocal is one
// more divide. An LED outside the bell (or any LED when the width is zero)
// skips the series and goes straight to the output. The series always runs
// one further term to find the zero, except when it stops at the 80-term
// limit. A frame is held whenever the output side stalls.
module gaussian_scanner_eye #(
    parameter int LEDS = 32     // 8 .. 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] frame_tick, [7:1] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [5:0] pixel_index, [13:6] pixel_red,
                                    // [21:14] pixel_green, [29:22] pixel_blue,
                                    // [31:30] zero
    output logic        m_tlast,    // last_pixel
    output logic        m_tuser,    // return_pause

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    localparam int IW = gse_pkg::IDX_W;
    localparam int CW = gse_pkg::COL_W;
    localparam int EW = gse_pkg::EYE_W;
    localparam int WW = gse_pkg::WT_W;

    localparam logic [6:0]    LEDS_V   = 7'(LEDS);
    localparam logic [EW-1:0] EYE_CAP  = EW'(LEDS - 1);
    localparam logic [IW-1:0] LAST_PIX = IW'(LEDS - 1);

    gse_pkg::gse_state_t state_reg, state_next;

    // Configuration.
    logic [CW-1:0] eye_red_reg, eye_green_reg, eye_blue_reg;
    logic [EW-1:0] eye_size_reg;

    // Frame and pixel state.
    logic [6:0]                 scan_reg;
    logic [6:0]                 c_reg;
    logic [2:0]                 w_reg;
    logic [6:0]                 den_reg;
    logic                       pause_reg;
    logic [IW-1:0]              pix_reg;
    logic [gse_pkg::NUM_W-1:0]  num_reg;
    logic [6:0]                 k_reg;
    logic [gse_pkg::T_W-1:0]    t_reg;
    logic [gse_pkg::ACC_W-1:0]  acc_reg;
    logic [WW-1:0]              wt_reg;

    // Output register.
    logic          m_valid_reg;
    logic [IW-1:0] m_index_reg;
    logic [CW-1:0] m_red_reg, m_green_reg, m_blue_reg;
    logic          m_last_reg;
    logic          m_pause_reg;

    // Shared unit.
    gse_pkg::gse_alu_req_t          alu_req;
    gse_pkg::gse_alu_stat_t         alu_stat;
    logic [gse_pkg::ALU_W-1:0]      alu_opa;
    logic [gse_pkg::DIVR_W-1:0]     alu_opb;
    logic [gse_pkg::ALU_W-1:0]      alu_result;

    logic in_fire;
    logic out_free;
    logic is_last;
    logic stop_series;

    // Frame set-up values.
    logic [EW-1:0] eye;
    logic [6:0]    span;
    logic [7:0]    period;
    logic [6:0]    s_cur;
    logic [6:0]    p_pos;
    logic [6:0]    centre;
    logic [7:0]    s_inc;
    logic          wrap;
    logic [5:0]    wsq;

    // Pixel values.
    logic [6:0]    pix_w;
    logic [6:0]    pix_dist;
    logic [12:0]   num;
    logic [10:0]   thr;
    logic          outside;
    logic [gse_pkg::DK_W-1:0] den_k;

    // Channel scaling.
    logic [24:0] red_prod, green_prod, blue_prod;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign is_last  = (pix_reg == LAST_PIX);

    always_comb begin
        eye = ({2'b0, eye_size_reg} >= LEDS_V) ? EYE_CAP : eye_size_reg;
        span   = LEDS_V - {2'b0, eye};
        period = {span, 1'b0};
        s_cur  = ({1'b0, scan_reg} >= period) ? 7'd0 : scan_reg;
        // The position bounces back once the counter passes the span.
        p_pos  = (s_cur < span) ? s_cur : 7'(period - {1'b0, s_cur});
        centre = p_pos + {3'b0, eye[EW-1:1]};
        s_inc  = {1'b0, s_cur} + 8'd1;
        wrap   = (s_inc >= period);
        wsq    = {3'b0, eye[EW-1:2]} * {3'b0, eye[EW-1:2]};
    end

    always_comb begin
        pix_w    = {1'b0, pix_reg};
        pix_dist = (pix_w >= c_reg) ? (pix_w - c_reg) : (c_reg - pix_w);
        num      = {6'b0, pix_dist} * {6'b0, pix_dist};
        thr      = {4'b0, den_reg} * gse_pkg::CUTOFF_MUL;
        outside  = (num >= {2'b0, thr});
        den_k    = {7'b0, den_reg} * {7'b0, k_reg};
    end

    assign stop_series = alu_stat.zero || (k_reg == gse_pkg::MAX_TERMS);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gse_pkg::ST_IDLE: begin
                if (in_fire && s_tdata[0]) begin
                    state_next = gse_pkg::ST_FRAME;
                end
            end
            gse_pkg::ST_FRAME: begin
                state_next = gse_pkg::ST_PIXEL;
            end
            gse_pkg::ST_PIXEL: begin
                if (w_reg == '0 || outside) begin
                    state_next = gse_pkg::ST_EMIT;
                end else begin
                    state_next = gse_pkg::ST_MUL;
                end
            end
            gse_pkg::ST_MUL: begin
                state_next = gse_pkg::ST_MUL_WAIT;
            end
            gse_pkg::ST_MUL_WAIT: begin
                if (alu_stat.done) begin
                    state_next = gse_pkg::ST_DIV;
                end
            end
            gse_pkg::ST_DIV: begin
                state_next = gse_pkg::ST_DIV_WAIT;
            end
            gse_pkg::ST_DIV_WAIT: begin
                if (alu_stat.done) begin
                    state_next = stop_series ? gse_pkg::ST_RECIP : gse_pkg::ST_MUL;
                end
            end
            gse_pkg::ST_RECIP: begin
                state_next = gse_pkg::ST_RECIP_WAIT;
            end
            gse_pkg::ST_RECIP_WAIT: begin
                if (alu_stat.done) begin
                    state_next = gse_pkg::ST_EMIT;
                end
            end
            gse_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = is_last ? gse_pkg::ST_IDLE : gse_pkg::ST_PIXEL;
                end
            end
            default: begin
                state_next = gse_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready      = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = gse_pkg::OP_DIV;
        alu_opa       = alu_result;
        alu_opb       = gse_pkg::DIVR_W'(den_k);
        unique case (state_reg)
            gse_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            gse_pkg::ST_MUL: begin
                alu_req.start = 1'b1;
                alu_req.op    = gse_pkg::OP_MUL;
                alu_opa       = gse_pkg::ALU_W'(t_reg);
                alu_opb       = gse_pkg::DIVR_W'(num_reg);
            end
            gse_pkg::ST_DIV: begin
                alu_req.start = 1'b1;
            end
            gse_pkg::ST_RECIP: begin
                alu_req.start = 1'b1;
                alu_opa       = gse_pkg::RECIP_NUM;
                alu_opb       = gse_pkg::DIVR_W'(acc_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gse_pkg::ST_IDLE;
            scan_reg      <= '0;
            eye_red_reg   <= 8'd255;
            eye_green_reg <= 8'd0;
            eye_blue_reg  <= 8'd0;
            eye_size_reg  <= 5'd8;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    gse_pkg::REG_EYE_RED:   eye_red_reg   <= cfg_wdata;
                    gse_pkg::REG_EYE_GREEN: eye_green_reg <= cfg_wdata;
                    gse_pkg::REG_EYE_BLUE:  eye_blue_reg  <= cfg_wdata;
                    gse_pkg::REG_EYE_SIZE:  eye_size_reg  <= cfg_wdata[EW-1:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == gse_pkg::ST_FRAME) begin
                scan_reg <= wrap ? 7'd0 : s_inc[6:0];
            end
            if (state_reg == gse_pkg::ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        red_prod   = {17'b0, eye_red_reg}   * {8'b0, wt_reg};
        green_prod = {17'b0, eye_green_reg} * {8'b0, wt_reg};
        blue_prod  = {17'b0, eye_blue_reg}  * {8'b0, wt_reg};
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            gse_pkg::ST_FRAME: begin
                c_reg     <= centre;
                w_reg     <= eye[EW-1:2];
                den_reg   <= {wsq, 1'b0};
                pause_reg <= wrap;
                pix_reg   <= '0;
            end
            gse_pkg::ST_PIXEL: begin
                if (w_reg == '0) begin
                    wt_reg <= (pix_dist == '0) ? gse_pkg::WEIGHT_ONE : '0;
                end else if (outside) begin
                    wt_reg <= '0;
                end
                num_reg <= num[gse_pkg::NUM_W-1:0];
                t_reg   <= gse_pkg::T_INIT;
                acc_reg <= gse_pkg::ACC_W'(gse_pkg::T_INIT);
                k_reg   <= 7'd1;
            end
            gse_pkg::ST_DIV_WAIT: begin
                if (alu_stat.done) begin
                    t_reg   <= alu_result[gse_pkg::T_W-1:0];
                    acc_reg <= acc_reg + gse_pkg::ACC_W'(alu_result[gse_pkg::T_W-1:0]);
                    k_reg   <= k_reg + 7'd1;
                end
            end
            gse_pkg::ST_RECIP_WAIT: begin
                if (alu_stat.done) begin
                    wt_reg <= alu_result[WW-1:0];
                end
            end
            gse_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_index_reg <= pix_reg;
                    m_red_reg   <= red_prod[23:16];
                    m_green_reg <= green_prod[23:16];
                    m_blue_reg  <= blue_prod[23:16];
                    m_last_reg  <= is_last;
                    m_pause_reg <= is_last && pause_reg;
                    pix_reg     <= pix_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    gse_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .stat    (alu_stat),
        .result  (alu_result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_blue_reg, m_green_reg, m_red_reg, m_index_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_pause_reg;

endmodule

`default_nettype wire
